[rtl/bdpc_pkg.sv]
package bdpc_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE   = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_LONG_PRESS = 1'd1;

  localparam logic [CfgW-1:0] DEBOUNCE_RESET   = 16'd50;
  localparam logic [CfgW-1:0] LONG_PRESS_RESET = 16'd1000;

endpackage

[rtl/button_debounce_press_classifier.sv]
// channel | direction | handshake          | payload
// --------+-----------+--------------------+-----------------------------------
// in      | in        | in_valid/in_ready  | now_ms, pin_pressed, edge_event
// out     | out       | out_valid/out_ready| short_press, long_press, fsm_state
// cfg     | in        | cfg_we             | cfg_index, cfg_data
//
// One poll per cycle unless stalled; each poll yields one registered word.
// The state update and result are one compare-and-select pass on 32-bit
// time differences, written straight into the state and result registers.
// in_ready stays high while the result register is empty or being drained.
// rst (synchronous) clears the state and timestamps and restores the
// configuration defaults.
module button_debounce_press_classifier (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bdpc_pkg::TimeW-1:0]     now_ms,
  input  logic                           pin_pressed,
  input  logic                           edge_event,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           short_press,
  output logic                           long_press,
  output logic [bdpc_pkg::PhaseW-1:0]    fsm_state,
  input  logic                           cfg_we,
  input  logic [bdpc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [bdpc_pkg::CfgW-1:0]      cfg_data
);
  import bdpc_pkg::*;

  typedef enum logic [PhaseW-1:0] {
    PH_IDLE    = 3'd0,
    PH_DEB_PR  = 3'd1,
    PH_PRESSED = 3'd2,
    PH_DEB_REL = 3'd3,
    PH_LONG    = 3'd4
  } phase_t;

  logic [CfgW-1:0]  debounce_ms;
  logic [CfgW-1:0]  long_press_ms;
  phase_t           phase;
  phase_t           phase_next;
  logic [TimeW-1:0] press_time;
  logic [TimeW-1:0] press_time_next;
  logic [TimeW-1:0] release_time;
  logic [TimeW-1:0] release_time_next;
  logic             edge_pending;
  logic             edge_pending_next;
  logic             long_seen;
  logic             long_seen_next;
  logic             short_next;
  logic             long_next;
  logic [TimeW-1:0] press_dt;
  logic [TimeW-1:0] release_dt;
  logic             press_deb_done;
  logic             release_deb_done;
  logic             long_due;
  logic             in_fire;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign press_dt         = now_ms - press_time;
  assign release_dt       = now_ms - release_time;
  assign press_deb_done   = press_dt >= {{(TimeW-CfgW){1'b0}}, debounce_ms};
  assign release_deb_done = release_dt >= {{(TimeW-CfgW){1'b0}}, debounce_ms};
  assign long_due         = press_dt >= {{(TimeW-CfgW){1'b0}}, long_press_ms};

  always_comb begin
    logic ep;
    ep                = edge_pending || edge_event;
    phase_next        = phase;
    press_time_next   = press_time;
    release_time_next = release_time;
    edge_pending_next = ep;
    long_seen_next    = long_seen;
    short_next        = 1'b0;
    long_next         = 1'b0;
    case (phase)
      PH_DEB_PR: begin
        if (press_deb_done) begin
          if (pin_pressed) begin
            phase_next     = PH_PRESSED;
            long_seen_next = 1'b0;
          end else begin
            phase_next = PH_IDLE;
          end
        end
      end
      PH_PRESSED: begin
        if (ep) begin
          edge_pending_next = 1'b0;
          if (!pin_pressed) begin
            phase_next        = PH_DEB_REL;
            release_time_next = now_ms;
          end
        end
        // long-press check wins over a release seen in the same poll
        if (!long_seen && long_due) begin
          long_seen_next = 1'b1;
          phase_next     = PH_LONG;
          long_next      = 1'b1;
        end
      end
      PH_DEB_REL: begin
        if (release_deb_done) begin
          if (!pin_pressed) begin
            short_next = !long_seen;
            phase_next = PH_IDLE;
          end else begin
            phase_next = PH_PRESSED;
          end
        end
      end
      PH_LONG: begin
        if (ep) begin
          edge_pending_next = 1'b0;
          if (!pin_pressed) begin
            phase_next        = PH_DEB_REL;
            release_time_next = now_ms;
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (ep) begin
          edge_pending_next = 1'b0;
          if (pin_pressed) begin
            phase_next      = PH_DEB_PR;
            press_time_next = now_ms;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms   <= DEBOUNCE_RESET;
      long_press_ms <= LONG_PRESS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE:   debounce_ms   <= cfg_data;
        REG_LONG_PRESS: long_press_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      press_time   <= '0;
      release_time <= '0;
      edge_pending <= 1'b0;
      long_seen    <= 1'b0;
      out_valid    <= 1'b0;
      short_press  <= 1'b0;
      long_press   <= 1'b0;
      fsm_state    <= PH_IDLE;
    end else begin
      if (in_fire) begin
        phase        <= phase_next;
        press_time   <= press_time_next;
        release_time <= release_time_next;
        edge_pending <= edge_pending_next;
        long_seen    <= long_seen_next;
        short_press  <= short_next;
        long_press   <= long_next;
        fsm_state    <= phase_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        // drop the word once taken
        out_valid <= 1'b0;
      end
    end
  end

  a_pulses_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(short_press && long_press))
    else $error("short and long press in one word");

  a_long_in_long_phase: assert property (@(posedge clk) disable iff (rst)
    (out_valid && long_press) |-> (fsm_state == PH_LONG) && long_seen)
    else $error("long press without long held phase");

  a_short_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && short_press) |-> (fsm_state == PH_IDLE) && !long_seen)
    else $error("short press not ending in idle");

  a_state_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fsm_state == phase))
    else $error("reported state differs from held phase");

  a_held_when_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(phase))
    else $error("phase advanced while result stalled");

endmodule

[tb/button_debounce_press_classifier_tb.sv]
module button_debounce_press_classifier_tb;
  import bdpc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int N_PHASES = 8;
  localparam int MAX_REPORTS = 10;
  localparam int HOLD_CYCLES = 400;

  typedef enum logic [PhaseW-1:0] {
    PH_IDLE        = 3'd0,
    PH_DEB_PRESS   = 3'd1,
    PH_PRESSED     = 3'd2,
    PH_DEB_RELEASE = 3'd3,
    PH_LONG_HELD   = 3'd4
  } phase_e;

  typedef struct packed {
    logic [TimeW-1:0] now;
    logic             pressed;
    logic             edge_ev;
  } poll_t;

  typedef struct packed {
    logic              short_p;
    logic              long_p;
    logic [PhaseW-1:0] phase;
  } press_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [TimeW-1:0] now_ms = '0;
  logic pin_pressed = 1'b0;
  logic edge_event = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic short_press;
  logic long_press;
  logic [PhaseW-1:0] fsm_state;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0] cfg_data = '0;

  button_debounce_press_classifier dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .now_ms(now_ms),
    .pin_pressed(pin_pressed),
    .edge_event(edge_event),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .short_press(short_press),
    .long_press(long_press),
    .fsm_state(fsm_state),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // button model state, mirrored from the block
  phase_e           cur_phase;
  logic [TimeW-1:0] press_t;
  logic [TimeW-1:0] release_t;
  logic             edge_pend;
  logic             long_seen;
  logic [CfgW-1:0]  debounce_cfg = DEBOUNCE_RESET;
  logic [CfgW-1:0]  long_cfg = LONG_PRESS_RESET;

  poll_t       poll_q[$];
  press_word_t press_word_q[$];

  int  n_errors = 0;
  int  n_words = 0;
  int  cycles = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  gaps_on = 1'b1;
  bit  stalls_on = 1'b1;
  bit  busy;
  poll_t       cur_poll;
  press_word_t got_word;
  press_word_t exp_word;

  // stimulus generator state
  logic [TimeW-1:0] t_now;
  logic             goal_level = 1'b0;
  logic             last_level = 1'b0;
  int               goal_left = 0;

  function automatic press_word_t classify_poll(poll_t p);
    press_word_t r;
    logic [TimeW-1:0] since_press;
    logic [TimeW-1:0] since_release;
    r = '0;
    since_press = p.now - press_t;
    since_release = p.now - release_t;
    if (p.edge_ev) edge_pend = 1'b1;
    case (cur_phase)
      PH_DEB_PRESS: begin
        if (since_press >= TimeW'(debounce_cfg)) begin
          if (p.pressed) begin
            cur_phase = PH_PRESSED;
            long_seen = 1'b0;
          end else begin
            cur_phase = PH_IDLE;
          end
        end
      end
      PH_PRESSED: begin
        if (edge_pend) begin
          edge_pend = 1'b0;
          if (!p.pressed) begin
            cur_phase = PH_DEB_RELEASE;
            release_t = p.now;
          end
        end
        // long press wins over a release seen in the same poll
        if (!long_seen && since_press >= TimeW'(long_cfg)) begin
          long_seen = 1'b1;
          cur_phase = PH_LONG_HELD;
          r.long_p = 1'b1;
        end
      end
      PH_DEB_RELEASE: begin
        if (since_release >= TimeW'(debounce_cfg)) begin
          if (!p.pressed) begin
            r.short_p = !long_seen;
            cur_phase = PH_IDLE;
          end else begin
            cur_phase = PH_PRESSED;
          end
        end
      end
      PH_LONG_HELD: begin
        if (edge_pend) begin
          edge_pend = 1'b0;
          if (!p.pressed) begin
            cur_phase = PH_DEB_RELEASE;
            release_t = p.now;
          end
        end
      end
      default: begin
        if (edge_pend) begin
          edge_pend = 1'b0;
          if (p.pressed) begin
            cur_phase = PH_DEB_PRESS;
            press_t = p.now;
          end else begin
            cur_phase = PH_IDLE;
          end
        end
      end
    endcase
    r.phase = cur_phase;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
      cur_phase = PH_IDLE;
      press_t = '0;
      release_t = '0;
      edge_pend = 1'b0;
      long_seen = 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        press_word_q.push_back(classify_poll(cur_poll));
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (poll_q.size() != 0) begin
          cur_poll = poll_q.pop_front();
          now_ms <= cur_poll.now;
          pin_pressed <= cur_poll.pressed;
          edge_event <= cur_poll.edge_ev;
          in_valid <= 1'b1;
          gap_left = gaps_on ? $urandom_range(0, 13) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        got_word = '{short_press, long_press, fsm_state};
        if (press_word_q.size() == 0) begin
          if (n_errors < MAX_REPORTS)
            $display("unexpected word: short=%0b long=%0b state=%0d",
                     short_press, long_press, fsm_state);
          n_errors++;
        end else begin
          exp_word = press_word_q.pop_front();
          if (got_word !== exp_word) begin
            if (n_errors < MAX_REPORTS)
              $display({"word %0d mismatch: exp short=%0b long=%0b state=%0d,",
                        " got short=%0b long=%0b state=%0d"},
                       n_words, exp_word.short_p, exp_word.long_p, exp_word.phase,
                       got_word.short_p, got_word.long_p, got_word.phase);
            n_errors++;
          end
        end
        n_words++;
        // hold off long enough to back up the input side
        if (n_words == 600 || n_words == 1400) hold_left = HOLD_CYCLES;
        stall_left = stalls_on ? $urandom_range(0, 13) : 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_DEBOUNCE) debounce_cfg = val;
    else long_cfg = val;
  endtask

  task automatic add_poll(input logic [TimeW-1:0] t, input logic p, input logic e);
    poll_t item;
    item.now = t;
    item.pressed = p;
    item.edge_ev = e;
    poll_q.push_back(item);
  endtask

  task automatic wait_drained();
    while (poll_q.size() != 0 || in_valid || press_word_q.size() != 0)
      @(posedge clk);
  endtask

  // bouncy button: a target level held for some polls, with glitches and
  // spurious edges, plus a share of fully random polls
  task automatic queue_button(input int n, input int unsigned step_max);
    poll_t item;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        item.now = $urandom;
        item.pressed = 1'($urandom_range(0, 1));
        item.edge_ev = 1'($urandom_range(0, 1));
      end else begin
        if (goal_left == 0) begin
          goal_level = !goal_level;
          goal_left = $urandom_range(1, 12);
        end
        goal_left--;
        t_now = t_now + $urandom_range(0, step_max);
        item.now = t_now;
        item.pressed = ($urandom_range(0, 7) == 0) ? !goal_level : goal_level;
        item.edge_ev = (item.pressed != last_level) || ($urandom_range(0, 15) == 0);
      end
      last_level = item.pressed;
      poll_q.push_back(item);
    end
  endtask

  initial begin
    int unsigned deb_set[N_PHASES];
    int unsigned long_set[N_PHASES];
    int unsigned step;
    deb_set  = '{0, 65535, 0,     65535, 3,  50,   0, 0};
    long_set = '{0, 65535, 65535, 1,     40, 1000, 0, 0};
    deb_set[6] = $urandom_range(0, 200);
    long_set[6] = $urandom_range(1, 2000);
    deb_set[7] = $urandom_range(0, 30);
    long_set[7] = $urandom_range(1, 300);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: debounce 50, long press 1000
    add_poll(32'hFFFF_FFFF, 1'b0, 1'b0);
    add_poll(32'd0,    1'b0, 1'b1);
    add_poll(32'd100,  1'b1, 1'b1);
    add_poll(32'd120,  1'b0, 1'b1);  // edge held pending through debounce
    add_poll(32'd150,  1'b1, 1'b0);
    add_poll(32'd160,  1'b1, 1'b0);
    add_poll(32'd200,  1'b0, 1'b1);
    add_poll(32'd230,  1'b1, 1'b0);
    add_poll(32'd250,  1'b0, 1'b0);  // short press
    add_poll(32'd1000, 1'b1, 1'b1);
    add_poll(32'd1060, 1'b1, 1'b0);
    add_poll(32'd2000, 1'b1, 1'b0);  // long press
    add_poll(32'd2010, 1'b0, 1'b1);
    add_poll(32'd2060, 1'b1, 1'b0);  // release rejected, long flag kept
    add_poll(32'd2100, 1'b0, 1'b1);
    add_poll(32'd2200, 1'b0, 1'b0);  // no short after a long press
    add_poll(32'hFFFF_FFF0, 1'b1, 1'b1);
    add_poll(32'h0000_0020, 1'b1, 1'b0);  // wrapped, just short of debounce
    add_poll(32'h0000_0022, 1'b1, 1'b0);
    add_poll(32'h0000_03E0, 1'b0, 1'b1);  // release and long press together
    add_poll(32'h0000_0400, 1'b0, 1'b0);
    add_poll(32'h0000_0410, 1'b0, 1'b1);
    add_poll(32'h0000_0500, 1'b0, 1'b0);
    wait_drained();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_reg(REG_DEBOUNCE, deb_set[ph][CfgW-1:0]);
      write_reg(REG_LONG_PRESS, long_set[ph][CfgW-1:0]);
      gaps_on = (ph % 3) != 1;
      stalls_on = (ph % 3) != 2;
      t_now = (ph == 1) ? 32'hFFFE_0000 : $urandom;
      step = ((deb_set[ph] > long_set[ph] ? deb_set[ph] : long_set[ph]) >> 2) + 2;
      queue_button(228, step);
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/bdpc_pkg.sv
rtl/button_debounce_press_classifier.sv
tb/button_debounce_press_classifier_tb.sv
